FILE: rtl/core/mi4_pkg.sv
package mi4_pkg;

   localparam int FRAC_BITS_DEF     = 16;
   localparam int ELEMENT_WIDTH_DEF = 32;

   // fixed widths of the channel fields
   localparam int ELEM_FIELD_W  = 32;
   localparam int VALUE_FIELD_W = 32;
   localparam int POS_W         = 4;

   // group numbering of the compute sequence
   localparam logic [4:0] GID_DET  = 5'd12;
   localparam logic [4:0] GID_ADJ0 = 5'd13;
   localparam logic [4:0] GID_LAST = 5'd28;

   localparam logic SRC_MAT = 1'b0;
   localparam logic SRC_VEC = 1'b1;

   typedef enum logic {DIV_ADJ, DIV_DET} div_sel_type;

   // one product term: +/- P * Q, each a matrix element or a 2W-bit vector
   typedef struct packed {
      logic       neg;
      logic       p_vec;
      logic [3:0] p_idx;
      logic       q_vec;
      logic [3:0] q_idx;
   } term_type;

   typedef struct packed {
      logic       is_vec;
      logic       hi;
      logic [3:0] idx;
   } opcode_type;

   typedef struct packed {
      logic        store_wr;
      logic [3:0]  store_idx;
      logic        opa_ld;
      logic        opb_ld;
      opcode_type  code;
      logic        mul_en;
      logic        acc_en;
      logic        acc_clr;
      logic        acc_neg;
      logic [1:0]  acc_shift;
      logic        vec_wr;
      logic [3:0]  vec_idx;
      logic        det_ld;
      logic        div_start;
      div_sel_type div_sel;
      logic        out_ld;
      logic        out_zero;
      logic [3:0]  out_pos;
      logic        out_last;
   } cmd_type;

   typedef struct packed {
      logic det_zero;
      logic div_done;
      logic out_free;
   } stat_type;

   function automatic term_type mk(logic neg, logic pv, logic [3:0] pi,
                                   logic qv, logic [3:0] qi);
      term_type t;
      t.neg   = neg;
      t.p_vec = pv;
      t.p_idx = pi;
      t.q_vec = qv;
      t.q_idx = qi;
      return t;
   endfunction

   // index of the final term of a group
   function automatic logic [2:0] last_term(logic [4:0] gid);
      if (gid < GID_DET) return 3'd1;
      else if (gid == GID_DET) return 3'd5;
      else return 3'd2;
   endfunction

   // vectors: s 0..2, t 3..5, u 6..8, v 9..11; group 12 is det; 13..28 adjugate
   function automatic term_type term_fn(logic [4:0] gid, logic [2:0] j);
      term_type   t;
      logic [1:0] k;
      logic [1:0] k1;
      logic [1:0] k2;
      logic [3:0] p;
      logic [3:0] kk;
      logic [3:0] kk1;
      logic [3:0] kk2;
      logic [3:0] jj;
      logic       j0;
      p = 4'(gid - GID_ADJ0);
      if (gid < 5'd3) k = gid[1:0];
      else if (gid < 5'd6) k = 2'(gid - 5'd3);
      else if (gid < 5'd9) k = 2'(gid - 5'd6);
      else if (gid < 5'd12) k = 2'(gid - 5'd9);
      else if (gid == GID_DET) k = 2'd0;
      else k = p[3:2];
      k1  = (k == 2'd2) ? 2'd0 : k + 2'd1;
      k2  = (k == 2'd0) ? 2'd2 : k - 2'd1;
      kk  = {2'b00, k};
      kk1 = {2'b00, k1};
      kk2 = {2'b00, k2};
      jj  = {1'b0, j};
      j0  = (j == 3'd0);
      if (gid < 5'd3) begin
         t = j0 ? mk(1'b0, SRC_MAT, kk1, SRC_MAT, 4'd4 + kk2)
                : mk(1'b1, SRC_MAT, kk2, SRC_MAT, 4'd4 + kk1);
      end else if (gid < 5'd6) begin
         t = j0 ? mk(1'b0, SRC_MAT, 4'd8 + kk1, SRC_MAT, 4'd12 + kk2)
                : mk(1'b1, SRC_MAT, 4'd8 + kk2, SRC_MAT, 4'd12 + kk1);
      end else if (gid < 5'd9) begin
         t = j0 ? mk(1'b0, SRC_MAT, kk, SRC_MAT, 4'd7)
                : mk(1'b1, SRC_MAT, 4'd4 + kk, SRC_MAT, 4'd3);
      end else if (gid < 5'd12) begin
         t = j0 ? mk(1'b0, SRC_MAT, 4'd8 + kk, SRC_MAT, 4'd15)
                : mk(1'b1, SRC_MAT, 4'd12 + kk, SRC_MAT, 4'd11);
      end else if (gid == GID_DET) begin
         if (j < 3'd3) t = mk(1'b0, SRC_VEC, jj, SRC_VEC, 4'd9 + jj);
         else t = mk(1'b0, SRC_VEC, jj, SRC_VEC, jj + 4'd3);
      end else begin
         case (p)
            4'd12: t = mk(1'b1, SRC_MAT, 4'd4 + jj, SRC_VEC, 4'd3 + jj);
            4'd13: t = mk(1'b0, SRC_MAT, jj, SRC_VEC, 4'd3 + jj);
            4'd14: t = mk(1'b1, SRC_MAT, 4'd12 + jj, SRC_VEC, jj);
            4'd15: t = mk(1'b0, SRC_MAT, 4'd8 + jj, SRC_VEC, jj);
            default: begin
               case (p[1:0])
                  2'd0: begin
                     if (j0) t = mk(1'b0, SRC_MAT, 4'd4 + kk1, SRC_VEC, 4'd9 + kk2);
                     else if (j == 3'd1)
                        t = mk(1'b1, SRC_MAT, 4'd4 + kk2, SRC_VEC, 4'd9 + kk1);
                     else t = mk(1'b0, SRC_VEC, 4'd3 + kk, SRC_MAT, 4'd7);
                  end
                  2'd1: begin
                     if (j0) t = mk(1'b0, SRC_VEC, 4'd9 + kk1, SRC_MAT, kk2);
                     else if (j == 3'd1) t = mk(1'b1, SRC_VEC, 4'd9 + kk2, SRC_MAT, kk1);
                     else t = mk(1'b1, SRC_VEC, 4'd3 + kk, SRC_MAT, 4'd3);
                  end
                  2'd2: begin
                     if (j0) t = mk(1'b0, SRC_MAT, 4'd12 + kk1, SRC_VEC, 4'd6 + kk2);
                     else if (j == 3'd1)
                        t = mk(1'b1, SRC_MAT, 4'd12 + kk2, SRC_VEC, 4'd6 + kk1);
                     else t = mk(1'b0, SRC_VEC, kk, SRC_MAT, 4'd15);
                  end
                  default: begin
                     if (j0) t = mk(1'b0, SRC_VEC, 4'd6 + kk1, SRC_MAT, 4'd8 + kk2);
                     else if (j == 3'd1)
                        t = mk(1'b1, SRC_VEC, 4'd6 + kk2, SRC_MAT, 4'd8 + kk1);
                     else t = mk(1'b1, SRC_VEC, kk, SRC_MAT, 4'd11);
                  end
               endcase
            end
         endcase
      end
      return t;
   endfunction

endpackage

FILE: rtl/core/mi4_if.sv
interface mi4_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [mi4_pkg::ELEM_FIELD_W-1:0] element;
   modport source (output valid, element, input ready);
   modport sink (input valid, element, output ready);
endinterface

interface mi4_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [mi4_pkg::VALUE_FIELD_W-1:0] value;
   logic [mi4_pkg::POS_W-1:0]               position;
   logic                                    singular;
   logic                                    clipped;
   logic                                    last;
   modport source (output valid, value, position, singular, clipped, last, input ready);
   modport sink (input valid, value, position, singular, clipped, last, output ready);
endinterface

interface mi4_csr_if;
   logic valid;
   logic ready;
   logic mode;
   modport source (output valid, mode, input ready);
   modport sink (input valid, mode, output ready);
endinterface

FILE: rtl/core/mi4_div.sv
module mi4_div #(
   parameter int NUM_W = 168,
   parameter int OUT_W = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] num,
   input  logic signed [NUM_W-1:0] den,
   output logic                    done,
   output logic signed [OUT_W-1:0] value,
   output logic                    clip
);

   localparam int N1 = NUM_W + 1;
   localparam int CW = $clog2(N1 + 1);

   typedef enum logic [1:0] {D_IDLE, D_PREP, D_RUN, D_FIN} phase_type;

   phase_type             phase_ff;
   logic [N1-1:0]         n_ff;
   logic [N1-1:0]         d_ff;
   logic [N1-1:0]         rem_ff;
   logic [N1-1:0]         q_ff;
   logic [CW-1:0]         cnt_ff;
   logic                  neg_ff;
   logic                  done_ff;
   logic signed [OUT_W-1:0] value_ff;
   logic                  clip_ff;

   logic [NUM_W-1:0] num_abs;
   logic [NUM_W-1:0] den_abs;
   logic [N1:0]      trial;
   logic [N1:0]      diff;
   logic [N1-1:0]    lim;
   logic             big;
   logic [N1-1:0]    mag;
   logic [OUT_W-1:0] mag_w;

   always_comb begin
      num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      den_abs = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
      trial   = {rem_ff, n_ff[N1-1]};
      diff    = trial - {1'b0, d_ff};
      lim     = (N1'(1) << (OUT_W - 1)) - N1'(!neg_ff);
      big     = q_ff > lim;
      mag     = big ? lim : q_ff;
      mag_w   = mag[OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (phase_ff)
            D_IDLE: begin
               if (start) begin
                  n_ff     <= N1'(num_abs);
                  d_ff     <= N1'(den_abs);
                  neg_ff   <= num[NUM_W-1] ^ den[NUM_W-1];
                  phase_ff <= D_PREP;
               end
            end
            D_PREP: begin
               // bias by half the divisor for round to nearest
               n_ff     <= (n_ff << 1) + d_ff;
               d_ff     <= d_ff << 1;
               rem_ff   <= '0;
               q_ff     <= '0;
               cnt_ff   <= CW'(N1);
               phase_ff <= D_RUN;
            end
            D_RUN: begin
               if (!diff[N1]) begin
                  rem_ff <= diff[N1-1:0];
                  q_ff   <= {q_ff[N1-2:0], 1'b1};
               end else begin
                  rem_ff <= trial[N1-1:0];
                  q_ff   <= {q_ff[N1-2:0], 1'b0};
               end
               n_ff   <= n_ff << 1;
               cnt_ff <= cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) phase_ff <= D_FIN;
            end
            D_FIN: begin
               value_ff <= neg_ff ? OUT_W'(-mag_w) : mag_w;
               clip_ff  <= big;
               done_ff  <= 1'b1;
               phase_ff <= D_IDLE;
            end
            default: phase_ff <= D_IDLE;
         endcase
      end
   end

   assign done  = done_ff;
   assign value = value_ff;
   assign clip  = clip_ff;

endmodule

FILE: rtl/core/mi4_dp.sv
module mi4_dp #(
   parameter int FRAC_BITS     = mi4_pkg::FRAC_BITS_DEF,
   parameter int ELEMENT_WIDTH = mi4_pkg::ELEMENT_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [mi4_pkg::ELEM_FIELD_W-1:0]  req_element,
   input  mi4_pkg::cmd_type                  cmd,
   output mi4_pkg::stat_type                 stat,
   mi4_rsp_if.source                         rsp_bus
);

   localparam int W     = ELEMENT_WIDTH;
   localparam int OPW   = W + 1;
   localparam int PRW   = 2 * W + 2;
   localparam int ACC_W = 4 * W + 2 * FRAC_BITS + 8;

   logic signed [W-1:0]     matrix_ff [16];
   logic [2*W-1:0]          vec_ff [12];
   logic signed [OPW-1:0]   opa_ff;
   logic signed [OPW-1:0]   opb_ff;
   logic signed [PRW-1:0]   prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] det_ff;

   logic                                 rsp_valid_ff;
   logic signed [mi4_pkg::VALUE_FIELD_W-1:0] rsp_value_ff;
   logic [mi4_pkg::POS_W-1:0]            rsp_pos_ff;
   logic                                 rsp_sing_ff;
   logic                                 rsp_clip_ff;
   logic                                 rsp_last_ff;

   logic signed [OPW-1:0]   op_bus;
   logic [2*W-1:0]          vec_rd;
   logic signed [ACC_W-1:0] term_ext;
   logic signed [ACC_W-1:0] term_sh;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [ACC_W-1:0] div_num;
   logic signed [ACC_W-1:0] div_den;
   logic                    div_done;
   logic signed [W-1:0]     div_value;
   logic                    div_clip;

   always_comb begin
      vec_rd = vec_ff[cmd.code.idx];
      if (!cmd.code.is_vec) op_bus = OPW'(matrix_ff[cmd.code.idx]);
      else if (cmd.code.hi) op_bus = OPW'($signed(vec_rd[2*W-1:W]));
      else op_bus = $signed({1'b0, vec_rd[W-1:0]});
      term_ext = ACC_W'(prod_ff);
      case (cmd.acc_shift)
         2'd0: term_sh = term_ext;
         2'd1: term_sh = term_ext <<< W;
         default: term_sh = term_ext <<< (2 * W);
      endcase
      acc_in = (cmd.acc_clr ? '0 : acc_ff) + (cmd.acc_neg ? -term_sh : term_sh);
      if (cmd.div_sel == mi4_pkg::DIV_DET) begin
         div_num = det_ff;
         div_den = ACC_W'(1) <<< (3 * FRAC_BITS);
      end else begin
         div_num = acc_ff <<< (2 * FRAC_BITS);
         div_den = det_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store_wr) matrix_ff[cmd.store_idx] <= req_element[W-1:0];
      if (cmd.opa_ld) opa_ff <= op_bus;
      if (cmd.opb_ld) opb_ff <= op_bus;
      if (cmd.mul_en) prod_ff <= opa_ff * opb_ff;
      if (cmd.acc_en) acc_ff <= acc_in;
      if (cmd.vec_wr) vec_ff[cmd.vec_idx] <= acc_ff[2*W-1:0];
      if (cmd.det_ld) det_ff <= acc_ff;
   end

   mi4_div #(
      .NUM_W (ACC_W),
      .OUT_W (W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .value (div_value),
      .clip  (div_clip)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_ld) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_ld) begin
         rsp_value_ff <= cmd.out_zero ? '0 : mi4_pkg::VALUE_FIELD_W'(div_value);
         rsp_clip_ff  <= cmd.out_zero ? 1'b0 : div_clip;
         rsp_sing_ff  <= cmd.out_zero;
         rsp_pos_ff   <= cmd.out_pos;
         rsp_last_ff  <= cmd.out_last;
      end
   end

   assign stat.det_zero = (det_ff == '0);
   assign stat.div_done = div_done;
   assign stat.out_free = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.value    = rsp_value_ff;
   assign rsp_bus.position = rsp_pos_ff;
   assign rsp_bus.singular = rsp_sing_ff;
   assign rsp_bus.clipped  = rsp_clip_ff;
   assign rsp_bus.last     = rsp_last_ff;

endmodule

FILE: rtl/core/mi4_ctrl.sv
module mi4_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              csr_valid,
   input  logic              csr_mode,
   input  mi4_pkg::stat_type stat,
   output mi4_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_LOAD, S_OPA, S_OPB, S_MUL, S_ACC, S_END, S_CHK, S_DIV, S_OUT, S_ZERO
   } state_type;

   state_type  state_ff;
   logic [3:0] cnt_ff;
   logic [4:0] gid_ff;
   logic [2:0] j_ff;
   logic       pp_ff;
   logic       qq_ff;
   logic       mode_ff;
   logic       run_mode_ff;

   mi4_pkg::term_type term;
   logic              last_q;
   logic              last_p;
   logic              last_t;
   logic              last_out;

   always_comb begin
      term     = mi4_pkg::term_fn(gid_ff, j_ff);
      last_q   = !term.q_vec || qq_ff;
      last_p   = !term.p_vec || pp_ff;
      last_t   = (j_ff == mi4_pkg::last_term(gid_ff));
      last_out = run_mode_ff || (gid_ff == mi4_pkg::GID_LAST);
      req_ready = (state_ff == S_LOAD);
      cmd = '0;
      cmd.store_wr  = (state_ff == S_LOAD) && req_valid;
      cmd.store_idx = cnt_ff;
      cmd.vec_idx   = gid_ff[3:0];
      cmd.out_pos   = run_mode_ff ? 4'd0 : 4'(gid_ff - mi4_pkg::GID_ADJ0);
      cmd.out_last  = last_out;
      cmd.div_sel   = (gid_ff == mi4_pkg::GID_DET) ? mi4_pkg::DIV_DET : mi4_pkg::DIV_ADJ;
      unique case (state_ff)
         S_LOAD: ;
         S_OPA: begin
            cmd.opa_ld = 1'b1;
            cmd.code   = '{is_vec: term.p_vec, hi: pp_ff, idx: term.p_idx};
         end
         S_OPB: begin
            cmd.opb_ld = 1'b1;
            cmd.code   = '{is_vec: term.q_vec, hi: qq_ff, idx: term.q_idx};
         end
         S_MUL: cmd.mul_en = 1'b1;
         S_ACC: begin
            cmd.acc_en    = 1'b1;
            cmd.acc_clr   = (j_ff == 3'd0) && !pp_ff && !qq_ff;
            cmd.acc_neg   = term.neg;
            cmd.acc_shift = 2'(term.p_vec & pp_ff) + 2'(term.q_vec & qq_ff);
         end
         S_END: begin
            if (gid_ff < mi4_pkg::GID_DET) cmd.vec_wr = 1'b1;
            else if (gid_ff == mi4_pkg::GID_DET) cmd.det_ld = 1'b1;
            else cmd.div_start = 1'b1;
         end
         S_CHK: cmd.div_start = !stat.det_zero && run_mode_ff;
         S_DIV: ;
         S_OUT: cmd.out_ld = stat.out_free;
         S_ZERO: begin
            cmd.out_ld   = stat.out_free;
            cmd.out_zero = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         cnt_ff      <= '0;
         gid_ff      <= '0;
         j_ff        <= '0;
         pp_ff       <= 1'b0;
         qq_ff       <= 1'b0;
         mode_ff     <= 1'b0;
         run_mode_ff <= 1'b0;
      end else begin
         if (csr_valid) mode_ff <= csr_mode;
         unique case (state_ff)
            S_LOAD: begin
               if (req_valid) begin
                  cnt_ff <= cnt_ff + 4'd1;
                  if (cnt_ff == 4'd15) begin
                     run_mode_ff <= mode_ff;
                     gid_ff      <= '0;
                     j_ff        <= '0;
                     pp_ff       <= 1'b0;
                     qq_ff       <= 1'b0;
                     state_ff    <= S_OPA;
                  end
               end
            end
            S_OPA: state_ff <= S_OPB;
            S_OPB: state_ff <= S_MUL;
            S_MUL: state_ff <= S_ACC;
            S_ACC: begin
               // walk low/high halves of Q, then of P, then the next term
               if (!last_q) begin
                  qq_ff    <= 1'b1;
                  state_ff <= S_OPA;
               end else begin
                  qq_ff <= 1'b0;
                  if (!last_p) begin
                     pp_ff    <= 1'b1;
                     state_ff <= S_OPA;
                  end else begin
                     pp_ff <= 1'b0;
                     if (last_t) begin
                        j_ff     <= '0;
                        state_ff <= S_END;
                     end else begin
                        j_ff     <= j_ff + 3'd1;
                        state_ff <= S_OPA;
                     end
                  end
               end
            end
            S_END: begin
               if (gid_ff < mi4_pkg::GID_DET) begin
                  gid_ff   <= gid_ff + 5'd1;
                  state_ff <= S_OPA;
               end else if (gid_ff == mi4_pkg::GID_DET) begin
                  state_ff <= S_CHK;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_CHK: begin
               if (stat.det_zero) begin
                  gid_ff   <= mi4_pkg::GID_ADJ0;
                  state_ff <= S_ZERO;
               end else if (run_mode_ff) begin
                  state_ff <= S_DIV;
               end else begin
                  gid_ff   <= mi4_pkg::GID_ADJ0;
                  state_ff <= S_OPA;
               end
            end
            S_DIV: if (stat.div_done) state_ff <= S_OUT;
            S_OUT: begin
               if (stat.out_free) begin
                  gid_ff   <= gid_ff + 5'd1;
                  state_ff <= last_out ? S_LOAD : S_OPA;
               end
            end
            S_ZERO: begin
               if (stat.out_free) begin
                  gid_ff <= gid_ff + 5'd1;
                  if (last_out) state_ff <= S_LOAD;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

endmodule

FILE: rtl/core/matrix_inverse_4x4.sv
// Loads sixteen elements at one beat per cycle, then computes on a shared
// 33x33 multiplier (load A, load B, multiply, accumulate per partial product)
// and a bit-serial divider (one quotient bit per cycle). One matrix at a time;
// no beat is taken while a matrix computes. Synchronous active-high reset
// clears control state.
module matrix_inverse_4x4 #(
   parameter int FRAC_BITS     = mi4_pkg::FRAC_BITS_DEF,
   parameter int ELEMENT_WIDTH = mi4_pkg::ELEMENT_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   mi4_req_if.sink   req_bus,
   mi4_rsp_if.source rsp_bus,
   mi4_csr_if.sink   csr_bus
);

   mi4_pkg::cmd_type  cmd;
   mi4_pkg::stat_type stat;

   assign csr_bus.ready = 1'b1;

   mi4_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .csr_valid (csr_bus.valid),
      .csr_mode  (csr_bus.mode),
      .stat      (stat),
      .cmd       (cmd)
   );

   mi4_dp #(
      .FRAC_BITS     (FRAC_BITS),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_element (req_bus.element),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_bus     (rsp_bus)
   );

endmodule

FILE: rtl/core/mi4_checker.sv
module mi4_checker #(
   parameter int ELEMENT_WIDTH = mi4_pkg::ELEMENT_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_value,
   input logic [3:0]  rsp_position,
   input logic        rsp_singular,
   input logic        rsp_clipped,
   input logic        rsp_last
);

   localparam logic [63:0] MAX_L = (64'd1 << (ELEMENT_WIDTH - 1)) - 64'd1;
   localparam logic [31:0] MAX_V = MAX_L[31:0];
   localparam logic [31:0] MIN_V = ~MAX_V;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_position))
      else $error("result beat changed while stalled");

   a_sing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_value == 32'd0 && !rsp_clipped)
      else $error("singular result not zero");

   a_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |-> (rsp_value == MAX_V || rsp_value == MIN_V))
      else $error("clipped value not at a bound");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_position == 4'd15 |-> rsp_last)
      else $error("final position without last");

   a_rst: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind matrix_inverse_4x4 mi4_checker #(
   .ELEMENT_WIDTH (ELEMENT_WIDTH)
) u_mi4_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_value    (rsp_bus.value),
   .rsp_position (rsp_bus.position),
   .rsp_singular (rsp_bus.singular),
   .rsp_clipped  (rsp_bus.clipped),
   .rsp_last     (rsp_bus.last)
);
